/* rtl/utt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package utt_pkg;

	localparam int unsigned POINT_W = 21;

	localparam logic [POINT_W-1:0] REPLACEMENT_POINT = 21'h00FFFD;
	localparam logic [POINT_W-1:0] MAX_POINT         = 21'h10FFFF;
	localparam logic [POINT_W-1:0] BMP_MAX           = 21'h00FFFF;
	localparam logic [POINT_W-1:0] SUPP_BASE         = 21'h010000;
	localparam logic [POINT_W-1:0] SURR_LOW          = 21'h00D800;
	localparam logic [POINT_W-1:0] SURR_HIGH         = 21'h00DFFF;
	localparam logic [POINT_W-1:0] MIN_TWO_BYTE      = 21'h000080;
	localparam logic [POINT_W-1:0] MIN_THREE_BYTE    = 21'h000800;
	localparam logic [5:0]         HI_SURR_TAG       = 6'b110110;
	localparam logic [5:0]         LO_SURR_TAG       = 6'b110111;
	localparam logic [1:0]         CONT_TAG          = 2'b10;

	typedef enum logic {
		FORM_UTF16 = 1'b0,
		FORM_UTF32 = 1'b1
	} form_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [POINT_W-1:0] code_value;
		logic               was_replaced;
		logic               last_of_run;
		logic               end_of_text;
	} result_t;

	typedef struct packed {
		result_t    res_a;
		result_t    res_b;
		logic [1:0] count;
	} decode_t;

endpackage

`default_nettype wire

/* rtl/utt_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface utt_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/utt_decode.sv */
`timescale 1ns / 1ps
`default_nettype none

module utt_decode (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire utt_pkg::in_item_t item,
	input  wire utt_pkg::form_t    output_form,
	output utt_pkg::decode_t       dec
);

	logic [utt_pkg::POINT_W-1:0] part_q, part_d;
	logic [1:0]                  due_q, due_d;
	logic [1:0]                  len_q, len_d;

	logic [utt_pkg::POINT_W-1:0] acc, mcp, off, lead_bits;
	logic [1:0]                  due_m1, lead_need;
	logic                        is_cont, acc_ok, pre, mv, mrep, expand, fin;
	logic [7:0]                  b;
	utt_pkg::result_t            bad_res, main_res, low_res;

	always_comb begin
		b       = item.text_byte;
		fin     = item.final_byte;
		is_cont = (b[7:6] == utt_pkg::CONT_TAG);
		acc     = {part_q[utt_pkg::POINT_W-7:0], b[5:0]};
		due_m1  = due_q - 2'd1;

		unique case (len_q)
			2'd1: acc_ok = (acc >= utt_pkg::MIN_TWO_BYTE);
			2'd2: acc_ok = (acc >= utt_pkg::MIN_THREE_BYTE)
				&& !((acc >= utt_pkg::SURR_LOW) && (acc <= utt_pkg::SURR_HIGH));
			default: acc_ok = (acc >= utt_pkg::SUPP_BASE) && (acc <= utt_pkg::MAX_POINT);
		endcase

		pre       = 1'b0;
		mv        = 1'b0;
		mcp       = '0;
		mrep      = 1'b0;
		part_d    = part_q;
		due_d     = due_q;
		len_d     = len_q;
		lead_need = 2'd0;
		lead_bits = '0;

		if ((due_q != 2'd0) && is_cont) begin
			if (due_m1 == 2'd0) begin
				mv     = 1'b1;
				part_d = '0;
				due_d  = 2'd0;
				len_d  = 2'd0;
				if (acc_ok) begin
					mcp = acc;
				end else begin
					mcp  = utt_pkg::REPLACEMENT_POINT;
					mrep = 1'b1;
				end
			end else if (fin) begin
				mv     = 1'b1;
				mcp    = utt_pkg::REPLACEMENT_POINT;
				mrep   = 1'b1;
				part_d = '0;
				due_d  = 2'd0;
				len_d  = 2'd0;
			end else begin
				part_d = acc;
				due_d  = due_m1;
			end
		end else begin
			pre    = (due_q != 2'd0);
			part_d = '0;
			due_d  = 2'd0;
			len_d  = 2'd0;
			priority if (!b[7]) begin
				mv  = 1'b1;
				mcp = {{(utt_pkg::POINT_W-8){1'b0}}, b};
			end else if (b[7:5] == 3'b110) begin
				lead_need = 2'd1;
				lead_bits = {{(utt_pkg::POINT_W-5){1'b0}}, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				lead_need = 2'd2;
				lead_bits = {{(utt_pkg::POINT_W-4){1'b0}}, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				lead_need = 2'd3;
				lead_bits = {{(utt_pkg::POINT_W-3){1'b0}}, b[2:0]};
			end else begin
				mv   = 1'b1;
				mcp  = utt_pkg::REPLACEMENT_POINT;
				mrep = 1'b1;
			end
			if (lead_need != 2'd0) begin
				if (fin) begin
					mv   = 1'b1;
					mcp  = utt_pkg::REPLACEMENT_POINT;
					mrep = 1'b1;
				end else begin
					part_d = lead_bits;
					due_d  = lead_need;
					len_d  = lead_need;
				end
			end
		end

		// surrogate pair split
		expand = mv && (output_form == utt_pkg::FORM_UTF16) && (mcp > utt_pkg::BMP_MAX);
		off    = mcp - utt_pkg::SUPP_BASE;

		bad_res = '{code_value: utt_pkg::REPLACEMENT_POINT, was_replaced: 1'b1,
			last_of_run: 1'b0, end_of_text: 1'b0};
		main_res = '{code_value: mcp, was_replaced: mrep,
			last_of_run: 1'b0, end_of_text: 1'b0};
		low_res = '{code_value: {5'b0, utt_pkg::LO_SURR_TAG, off[9:0]}, was_replaced: mrep,
			last_of_run: 1'b0, end_of_text: 1'b0};
		if (expand) begin
			main_res.code_value = {5'b0, utt_pkg::HI_SURR_TAG, off[19:10]};
		end

		dec.count = {1'b0, pre} + {1'b0, mv} + {1'b0, expand};
		if (pre) begin
			dec.res_a = bad_res;
			dec.res_b = main_res;
		end else begin
			dec.res_a = main_res;
			dec.res_b = low_res;
		end

		if (dec.count == 2'd2) begin
			dec.res_b.last_of_run = 1'b1;
			dec.res_b.end_of_text = fin;
		end else begin
			dec.res_a.last_of_run = 1'b1;
			dec.res_a.end_of_text = fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			due_q  <= 2'd0;
			len_q  <= 2'd0;
		end else if (advance) begin
			part_q <= part_d;
			due_q  <= due_d;
			len_q  <= len_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/utt_outbuf.sv */
`timescale 1ns / 1ps
`default_nettype none

module utt_outbuf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire utt_pkg::decode_t dec,
	output logic                  can_load,
	utt_stream_if.source          code_out
);

	utt_pkg::result_t slot0_q, slot1_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign pop            = code_out.valid && code_out.ready;
	assign code_out.valid = (cnt_q != 2'd0);
	assign code_out.data  = slot0_q;
	assign can_load       = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && code_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= dec.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= dec.res_a;
			slot1_q <= dec.res_b;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/utf8_to_utf16_transcoder.sv */
// path: a text byte is registered in the input stage, decoded combinationally, and its
//   result items are registered in the two-entry result buffer that drives code_out
// throughput: one byte per cycle while code_out is ready; a byte that yields two items
//   (surrogate pair, or replacement plus a new point) holds the buffer until one is taken
// reset: arst_n clears the sequence state, the buffers and output_form (utf-16)
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_transcoder (
	input  wire logic    clk,
	input  wire logic    arst_n,
	utt_stream_if.sink   text_in,
	utt_stream_if.source code_out,
	utt_stream_if.sink   cfg
);

	utt_pkg::in_item_t item_s1;
	logic              valid_s1;
	utt_pkg::form_t    form_q;
	utt_pkg::decode_t  dec;
	logic              can_load, advance, take;

	assign advance       = valid_s1 && can_load;
	assign text_in.ready = !valid_s1 || advance;
	assign take          = text_in.valid && text_in.ready;
	assign cfg.ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			form_q   <= utt_pkg::FORM_UTF16;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				form_q <= utt_pkg::form_t'(cfg.data);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= text_in.data;
		end
	end

	utt_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.item        (item_s1),
		.output_form (form_q),
		.dec         (dec)
	);

	utt_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.dec      (dec),
		.can_load (can_load),
		.code_out (code_out)
	);

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	typedef logic [utt_pkg::POINT_W-1:0] point_t;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 6;
	localparam int PHASE_ITEMS  = 400;

	logic clk;
	logic arst_n;

	utt_stream_if #(.payload_t(utt_pkg::in_item_t)) text_if ();
	utt_stream_if #(.payload_t(utt_pkg::result_t))  code_if ();
	utt_stream_if                                   cfg_if ();

	utf8_to_utf16_transcoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_if),
		.code_out (code_if),
		.cfg      (cfg_if)
	);

	utt_pkg::in_item_t pending_bytes[$];
	utt_pkg::result_t  expected_units[$];
	utt_pkg::result_t  staged_units[$];
	logic [7:0]        seq_bytes[$];

	// decoder state as the block should hold it
	utt_pkg::form_t pred_form;
	point_t         pred_partial;
	logic [1:0]     pred_due;
	logic [1:0]     pred_len;

	int errors;
	int queued_bytes;
	int taken_bytes;
	int checked_units;
	int replaced_units;
	int pair_units;
	int final_bytes;
	int cycles;
	int tx_gap, tx_calm, rx_stall, rx_calm;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 50)
			$display("mismatch: %s", msg);
	endtask

	// ---- prediction
	task automatic stage_unit(input point_t value, input logic repl);
		utt_pkg::result_t u;
		u.code_value   = value;
		u.was_replaced = repl;
		u.last_of_run  = 1'b0;
		u.end_of_text  = 1'b0;
		staged_units.insert(staged_units.size(), u);
	endtask

	task automatic stage_point(input point_t cp, input logic repl);
		point_t off;
		if (pred_form == utt_pkg::FORM_UTF16 && cp > utt_pkg::BMP_MAX) begin
			off = cp - utt_pkg::SUPP_BASE;
			stage_unit({5'b0, utt_pkg::HI_SURR_TAG, off[19:10]}, repl);
			stage_unit({5'b0, utt_pkg::LO_SURR_TAG, off[9:0]}, repl);
		end else begin
			stage_unit(cp, repl);
		end
	endtask

	task automatic clear_seq();
		pred_partial = '0;
		pred_due     = '0;
		pred_len     = '0;
	endtask

	task automatic open_seq(input point_t bits, input logic [1:0] need,
			input logic fin);
		if (fin) begin
			stage_unit(utt_pkg::REPLACEMENT_POINT, 1'b1);
			clear_seq();
		end else begin
			pred_partial = bits;
			pred_due     = need;
			pred_len     = need;
		end
	endtask

	task automatic predict_byte(input utt_pkg::in_item_t it);
		logic [7:0] b;
		logic       fin;
		point_t     cp;
		logic       ok;
		b   = it.text_byte;
		fin = it.final_byte;
		staged_units.delete();
		if (pred_due != 0 && b[7:6] == utt_pkg::CONT_TAG) begin
			pred_partial = {pred_partial[utt_pkg::POINT_W-7:0], b[5:0]};
			pred_due     = pred_due - 2'd1;
			if (pred_due == 0) begin
				cp = pred_partial;
				if (pred_len == 2'd1)
					ok = (cp >= utt_pkg::MIN_TWO_BYTE);
				else if (pred_len == 2'd2)
					ok = (cp >= utt_pkg::MIN_THREE_BYTE)
						&& !(cp >= utt_pkg::SURR_LOW && cp <= utt_pkg::SURR_HIGH);
				else
					ok = (cp >= utt_pkg::SUPP_BASE) && (cp <= utt_pkg::MAX_POINT);
				if (ok)
					stage_point(cp, 1'b0);
				else
					stage_unit(utt_pkg::REPLACEMENT_POINT, 1'b1);
				clear_seq();
			end else if (fin) begin
				stage_unit(utt_pkg::REPLACEMENT_POINT, 1'b1);
				clear_seq();
			end
		end else begin
			if (pred_due != 0) begin
				stage_unit(utt_pkg::REPLACEMENT_POINT, 1'b1);
				clear_seq();
			end
			if (b[7] == 1'b0)
				stage_point({13'b0, b}, 1'b0);
			else if (b[7:5] == 3'b110)
				open_seq({16'b0, b[4:0]}, 2'd1, fin);
			else if (b[7:4] == 4'b1110)
				open_seq({17'b0, b[3:0]}, 2'd2, fin);
			else if (b[7:3] == 5'b11110)
				open_seq({18'b0, b[2:0]}, 2'd3, fin);
			else
				stage_unit(utt_pkg::REPLACEMENT_POINT, 1'b1);
		end
		if (staged_units.size() > 0) begin
			staged_units[staged_units.size()-1].last_of_run = 1'b1;
			staged_units[staged_units.size()-1].end_of_text = fin;
		end
		foreach (staged_units[i])
			expected_units.insert(expected_units.size(), staged_units[i]);
	endtask

	// ---- stimulus
	task automatic queue_byte(input logic [7:0] b, input logic fin);
		utt_pkg::in_item_t it;
		it.text_byte  = b;
		it.final_byte = fin;
		pending_bytes.insert(pending_bytes.size(), it);
		queued_bytes++;
	endtask

	task automatic add_seq_byte(input logic [7:0] b);
		seq_bytes.insert(seq_bytes.size(), b);
	endtask

	function automatic point_t rand_point(input int n);
		case (n)
			1: return point_t'($urandom_range(0, 'h7F));
			2: return point_t'($urandom_range('h80, 'h7FF));
			3: return point_t'($urandom_range('h800, 'hFFFF));
			default: return point_t'($urandom_range('h10000, 'h10FFFF));
		endcase
	endfunction

	task automatic encode_point(input point_t cp, input int n);
		seq_bytes.delete();
		case (n)
			1: add_seq_byte({1'b0, cp[6:0]});
			2: begin
				add_seq_byte({3'b110, cp[10:6]});
				add_seq_byte({utt_pkg::CONT_TAG, cp[5:0]});
			end
			3: begin
				add_seq_byte({4'b1110, cp[15:12]});
				add_seq_byte({utt_pkg::CONT_TAG, cp[11:6]});
				add_seq_byte({utt_pkg::CONT_TAG, cp[5:0]});
			end
			default: begin
				add_seq_byte({5'b11110, cp[20:18]});
				add_seq_byte({utt_pkg::CONT_TAG, cp[17:12]});
				add_seq_byte({utt_pkg::CONT_TAG, cp[11:6]});
				add_seq_byte({utt_pkg::CONT_TAG, cp[5:0]});
			end
		endcase
	endtask

	task automatic queue_sequence();
		int         kind, n, k;
		point_t     cp;
		logic [7:0] b;
		logic       force_fin;
		force_fin = 1'b0;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			n  = $urandom_range(1, 4);
			cp = rand_point(n);
			if (n == 3 && cp >= utt_pkg::SURR_LOW && cp <= utt_pkg::SURR_HIGH)
				cp = cp ^ 21'h002000;
			encode_point(cp, n);
		end else if (kind < 55) begin
			// overlong
			n = $urandom_range(2, 4);
			cp = (n == 2) ? point_t'($urandom_range(0, 'h7F)) :
				(n == 3) ? point_t'($urandom_range(0, 'h7FF)) :
				point_t'($urandom_range(0, 'hFFFF));
			encode_point(cp, n);
		end else if (kind < 62) begin
			encode_point(point_t'($urandom_range('h110000, 'h1FFFFF)), 4);
		end else if (kind < 68) begin
			encode_point(point_t'($urandom_range('hD800, 'hDFFF)), 3);
		end else if (kind < 80) begin
			// sequence cut short, either interrupted or ended by the final flag
			n = $urandom_range(2, 4);
			encode_point(rand_point(n), n);
			k = $urandom_range(1, n - 1);
			while (seq_bytes.size() > k)
				void'(seq_bytes.pop_back());
			if ($urandom_range(0, 1)) begin
				b = 8'($urandom_range(0, 255));
				if (b[7:6] == utt_pkg::CONT_TAG)
					b[6] = 1'b1;
				add_seq_byte(b);
			end else begin
				force_fin = 1'b1;
			end
		end else if (kind < 92) begin
			seq_bytes.delete();
			add_seq_byte(8'($urandom_range(0, 255)));
		end else begin
			seq_bytes.delete();
			n = $urandom_range(1, 3);
			repeat (n) begin
				if ($urandom_range(0, 1))
					add_seq_byte(8'($urandom_range('h80, 'hBF)));
				else
					add_seq_byte(8'($urandom_range('hF8, 'hFF)));
			end
		end
		foreach (seq_bytes[i]) begin
			if (i == seq_bytes.size() - 1)
				queue_byte(seq_bytes[i], force_fin || ($urandom_range(0, 11) == 0));
			else
				queue_byte(seq_bytes[i], 1'b0);
		end
	endtask

	task automatic queue_random(input int amount);
		int target;
		target = queued_bytes + amount;
		while (queued_bytes < target)
			queue_sequence();
		queue_byte(8'h0A, 1'b1);
	endtask

	task automatic queue_directed();
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h7F, 1'b0);
		// overlong two-byte form
		queue_byte(8'hC0, 1'b0);
		queue_byte(8'hAF, 1'b0);
		// surrogate
		queue_byte(8'hED, 1'b0);
		queue_byte(8'hA0, 1'b0);
		queue_byte(8'h80, 1'b0);
		// genuine replacement character
		queue_byte(8'hEF, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBD, 1'b0);
		// highest code point
		queue_byte(8'hF4, 1'b0);
		queue_byte(8'h8F, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b0);
		// above range
		queue_byte(8'hF4, 1'b0);
		queue_byte(8'h90, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h80, 1'b0);
		// bad leads
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h80, 1'b0);
		// interrupted sequence
		queue_byte(8'hC2, 1'b0);
		queue_byte(8'h41, 1'b0);
		// cut short by the final byte
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h82, 1'b1);
	endtask

	task automatic write_form(input utt_pkg::form_t f);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= f;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() > 0 || text_if.valid || expected_units.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ---- byte driver
	always @(posedge clk) begin
		if (!arst_n) begin
			text_if.valid <= 1'b0;
			tx_gap = 0;
		end else if (!text_if.valid || text_if.ready) begin
			if (tx_calm > 0)
				tx_calm--;
			else if ($urandom_range(0, 149) == 0)
				tx_calm = $urandom_range(40, 120);
			if (tx_gap > 0) begin
				tx_gap--;
				text_if.valid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				text_if.data  <= pending_bytes.pop_front();
				text_if.valid <= 1'b1;
				tx_gap = (tx_calm > 0) ? 0 : pick_gap();
			end else begin
				text_if.valid <= 1'b0;
			end
		end
	end

	// ---- result backpressure
	always @(posedge clk) begin
		if (!arst_n) begin
			code_if.ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (rx_calm > 0)
				rx_calm--;
			else if ($urandom_range(0, 149) == 0)
				rx_calm = $urandom_range(40, 120);
			if (rx_stall > 0) begin
				rx_stall--;
				code_if.ready <= 1'b0;
			end else begin
				code_if.ready <= 1'b1;
				if (rx_calm == 0 && $urandom_range(0, 3) == 0)
					rx_stall = pick_gap();
			end
		end
	end

	// ---- monitor and checker
	always @(posedge clk) begin
		utt_pkg::result_t got, want;
		if (!arst_n) begin
			pred_form = utt_pkg::FORM_UTF16;
			clear_seq();
		end else begin
			if (cfg_if.valid && cfg_if.ready)
				pred_form = utt_pkg::form_t'(cfg_if.data);
			if (text_if.valid && text_if.ready) begin
				taken_bytes++;
				if (text_if.data.final_byte)
					final_bytes++;
				predict_byte(text_if.data);
			end
			if (code_if.valid && code_if.ready) begin
				got = code_if.data;
				checked_units++;
				if (got.was_replaced)
					replaced_units++;
				if (got.code_value >= utt_pkg::SURR_LOW && got.code_value <= utt_pkg::SURR_HIGH)
					pair_units++;
				if (expected_units.size() == 0) begin
					report_mismatch($sformatf("unexpected item %06h r%0b l%0b e%0b",
						got.code_value, got.was_replaced, got.last_of_run, got.end_of_text));
				end else begin
					want = expected_units.pop_front();
					if (got.code_value !== want.code_value ||
							got.was_replaced !== want.was_replaced ||
							got.last_of_run !== want.last_of_run ||
							got.end_of_text !== want.end_of_text)
						report_mismatch($sformatf(
							"item %0d got %06h r%0b l%0b e%0b want %06h r%0b l%0b e%0b",
							checked_units, got.code_value, got.was_replaced,
							got.last_of_run, got.end_of_text, want.code_value,
							want.was_replaced, want.last_of_run, want.end_of_text));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		text_if.valid = 1'b0;
		text_if.data  = '0;
		code_if.ready = 1'b0;
		cfg_if.valid  = 1'b0;
		cfg_if.data   = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_form(utt_pkg::FORM_UTF16);
		queue_directed();
		queue_random(PHASE_ITEMS);
		wait_drained();

		write_form(utt_pkg::FORM_UTF32);
		queue_directed();
		queue_random(PHASE_ITEMS);
		wait_drained();

		write_form(utt_pkg::FORM_UTF16);
		queue_random(PHASE_ITEMS);
		wait_drained();

		write_form(utt_pkg::FORM_UTF32);
		queue_random(PHASE_ITEMS);
		wait_drained();

		$display("covered %0d text bytes (%0d final) over four output-form phases",
			taken_bytes, final_bytes);
		$display("checked %0d code items: %0d replacements, %0d surrogate halves",
			checked_units, replaced_units, pair_units);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
